// File: rtl/sjf_pkg.sv
// Shared types, widths and constants for the servo joystick filter and mapper.
package sjf_pkg;

  localparam int unsigned CH_W      = 2;
  localparam int unsigned NUM_CH    = 4;
  localparam int unsigned SAMPLE_W  = 8;
  localparam int unsigned ANGLE_W   = 8;
  localparam int unsigned PULSE_W   = 16;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned NUM_CFG   = 8;

  // Shared multiplier operand and product widths
  localparam int unsigned MUL_A_W     = 24;
  localparam int unsigned MUL_B_W     = 29;
  localparam int unsigned MUL_P_W     = MUL_A_W + MUL_B_W;
  localparam int unsigned RECIP_SHIFT = 32;

  // Reciprocals ceil(2^32 / d): exact floor division for every dividend below 2^24
  localparam logic [MUL_B_W-1:0] RECIP_127 = 29'd33818641;
  localparam logic [MUL_B_W-1:0] RECIP_255 = 29'd16843010;
  localparam logic [MUL_B_W-1:0] RECIP_10  = 29'd429496730;
  localparam logic [MUL_B_W-1:0] RECIP_180 = 29'd23860930;

  localparam logic [MUL_B_W-1:0] ANGLE_SCALE = 29'd180;
  localparam logic [MUL_B_W-1:0] OLD_WEIGHT  = 29'd9;
  localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 8'd180;
  localparam logic [SAMPLE_W-1:0] HALF_MAX   = 8'd127;
  localparam logic [SAMPLE_W-1:0] SAMPLE_TOP = 8'd255;

  // Channel roles
  localparam logic [CH_W-1:0] INV_CH  = 2'd1;
  localparam logic [CH_W-1:0] FULL_CH = 2'd3;

  localparam logic [PULSE_W-1:0] LO_RESET = 16'd1000;
  localparam logic [PULSE_W-1:0] HI_RESET = 16'd2000;

  typedef struct packed {
    logic               en;
    logic [MUL_A_W-1:0] a;
    logic [MUL_B_W-1:0] b;
  } mul_req_t;

  typedef struct packed {
    logic [PULSE_W-1:0] lo;
    logic [PULSE_W-1:0] hi;
  } servo_range_t;

endpackage

// File: rtl/servo_joystick_filter_map.sv
// Top level: sequencer, filter state and output register of the servo mapper.
//
// Input stream: s_axis_tuser carries the converter channel, s_axis_tdata the
// 8-bit sample. Output stream: m_axis_tuser carries the servo index,
// m_axis_tdata the pulse compare value, the filtered angle and the next
// channel to convert. Every input transaction yields exactly one output.
// Each item runs through six steps of one shared multiplier: sample scaling,
// reciprocal division to an angle, filter weighting, reciprocal division by
// ten, range scaling and reciprocal division by 180. The result is loaded
// into the output register in a final state after these steps, and a new
// item is taken only once the sequencer is back in idle.
// The output register holds a result until it is taken; while it is still
// full at the end of the next item, the sequencer waits and s_axis_tready
// stays low. Reset clears the filtered angles to zero and loads every servo
// range with 1000 to 2000. Range registers are written through cfg_we_i,
// cfg_idx_i and cfg_data_i; the user must do so only while the block is idle,
// as the block does not enforce it; indexes above seven are ignored.
module servo_joystick_filter_map (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [7:0]                     s_axis_tdata,  // [7:0] sample
  input  logic [1:0]                     s_axis_tuser,  // [1:0] channel
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [15:0] pulse, [23:16] filtered_angle, [25:24] next_channel, rest zero
  output logic [31:0]                    m_axis_tdata,
  output logic [1:0]                     m_axis_tuser,  // [1:0] servo
  input  logic                           cfg_we_i,
  input  logic [sjf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [sjf_pkg::PULSE_W-1:0]    cfg_data_i
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ANG_MUL,
    ST_ANG_DIV,
    ST_FLT_MUL,
    ST_FLT_DIV,
    ST_PUL_MUL,
    ST_PUL_DIV,
    ST_FIN
  } state_e;

  state_e                          state_q;
  logic [sjf_pkg::CH_W-1:0]        ch_q;
  logic [sjf_pkg::SAMPLE_W-1:0]    samp_q;
  logic                            sat_q;
  logic                            full_q;
  logic                            neg_q;
  logic [sjf_pkg::ANGLE_W-1:0]     old_q;
  logic [sjf_pkg::ANGLE_W-1:0]     ang_q;
  logic [sjf_pkg::ANGLE_W-1:0]     f_q;
  logic [sjf_pkg::ANGLE_W-1:0]     filt_q [sjf_pkg::NUM_CH];
  logic                            out_valid_q;
  logic [sjf_pkg::CH_W-1:0]        out_servo_q;
  logic [sjf_pkg::PULSE_W-1:0]     out_pulse_q;
  logic [sjf_pkg::ANGLE_W-1:0]     out_angle_q;
  logic [sjf_pkg::CH_W-1:0]        out_next_q;

  sjf_pkg::mul_req_t               mul_req;
  logic [sjf_pkg::MUL_P_W-1:0]     prod;
  logic [sjf_pkg::PULSE_W-1:0]     quo;
  sjf_pkg::servo_range_t           range;
  logic                            diff_neg;
  logic [sjf_pkg::PULSE_W-1:0]     diff_mag;
  logic [sjf_pkg::SAMPLE_W-1:0]    samp_in;
  logic [sjf_pkg::PULSE_W-1:0]     pulse_new;
  logic                            in_fire;
  logic                            out_load;

  sjf_mul_unit u_mul (
    .clk_i  (clk_i),
    .req_i  (mul_req),
    .prod_o (prod)
  );

  sjf_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (cfg_we_i),
    .idx_i   (cfg_idx_i),
    .data_i  (cfg_data_i),
    .ch_i    (ch_q),
    .range_o (range)
  );

  // Quotient of the last reciprocal step
  assign quo = prod[sjf_pkg::RECIP_SHIFT +: sjf_pkg::PULSE_W];

  // Invert the sample on the inverted channel
  assign samp_in = (s_axis_tuser == sjf_pkg::INV_CH) ?
                   (sjf_pkg::SAMPLE_TOP - s_axis_tdata) : s_axis_tdata;

  // Signed range as sign and magnitude
  assign diff_neg = range.hi < range.lo;
  assign diff_mag = diff_neg ? (range.lo - range.hi) : (range.hi - range.lo);

  // Apply the truncated scaled offset, wrapping to the pulse width
  assign pulse_new = neg_q ? (range.lo - quo) : (range.lo + quo);

  assign s_axis_tready = (state_q == ST_IDLE);
  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign out_load      = (state_q == ST_FIN) && (!out_valid_q || m_axis_tready);

  // Select the operands of the shared multiplier for each step
  always_comb begin
    mul_req = '0;
    unique case (state_q)
      ST_ANG_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = sjf_pkg::MUL_A_W'(samp_q);
        mul_req.b  = sjf_pkg::ANGLE_SCALE;
      end
      ST_ANG_DIV: begin
        mul_req.en = 1'b1;
        mul_req.a  = prod[sjf_pkg::MUL_A_W-1:0];
        mul_req.b  = full_q ? sjf_pkg::RECIP_255 : sjf_pkg::RECIP_127;
      end
      ST_FLT_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = sjf_pkg::MUL_A_W'(old_q);
        mul_req.b  = sjf_pkg::OLD_WEIGHT;
      end
      ST_FLT_DIV: begin
        mul_req.en = 1'b1;
        mul_req.a  = prod[sjf_pkg::MUL_A_W-1:0] + sjf_pkg::MUL_A_W'(ang_q);
        mul_req.b  = sjf_pkg::RECIP_10;
      end
      ST_PUL_MUL: begin
        mul_req.en = 1'b1;
        mul_req.a  = sjf_pkg::MUL_A_W'(quo[sjf_pkg::ANGLE_W-1:0]);
        mul_req.b  = sjf_pkg::MUL_B_W'(diff_mag);
      end
      ST_PUL_DIV: begin
        mul_req.en = 1'b1;
        mul_req.a  = prod[sjf_pkg::MUL_A_W-1:0];
        mul_req.b  = sjf_pkg::RECIP_180;
      end
      default: begin
        mul_req = '0;
      end
    endcase
  end

  // Sequencer, filter state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ch_q        <= '0;
      samp_q      <= '0;
      sat_q       <= 1'b0;
      full_q      <= 1'b0;
      neg_q       <= 1'b0;
      old_q       <= '0;
      ang_q       <= '0;
      f_q         <= '0;
      for (int i = 0; i < sjf_pkg::NUM_CH; i++) begin
        filt_q[i] <= '0;
      end
      out_valid_q <= 1'b0;
      out_servo_q <= '0;
      out_pulse_q <= '0;
      out_angle_q <= '0;
      out_next_q  <= '0;
    end else begin
      // Drop the output once the receiver takes it, unless a new one replaces it
      if (out_valid_q && m_axis_tready && !out_load) begin
        out_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (in_fire) begin
            ch_q    <= s_axis_tuser;
            samp_q  <= samp_in;
            full_q  <= (s_axis_tuser == sjf_pkg::FULL_CH);
            sat_q   <= (s_axis_tuser != sjf_pkg::FULL_CH) && (samp_in > sjf_pkg::HALF_MAX);
            old_q   <= filt_q[s_axis_tuser];
            state_q <= ST_ANG_MUL;
          end
        end
        ST_ANG_MUL: begin
          state_q <= ST_ANG_DIV;
        end
        ST_ANG_DIV: begin
          state_q <= ST_FLT_MUL;
        end
        ST_FLT_MUL: begin
          ang_q   <= sat_q ? sjf_pkg::ANGLE_MAX : quo[sjf_pkg::ANGLE_W-1:0];
          state_q <= ST_FLT_DIV;
        end
        ST_FLT_DIV: begin
          state_q <= ST_PUL_MUL;
        end
        ST_PUL_MUL: begin
          f_q          <= quo[sjf_pkg::ANGLE_W-1:0];
          filt_q[ch_q] <= quo[sjf_pkg::ANGLE_W-1:0];
          neg_q        <= diff_neg;
          state_q      <= ST_PUL_DIV;
        end
        ST_PUL_DIV: begin
          state_q <= ST_FIN;
        end
        ST_FIN: begin
          // Hold here while the previous result is still waiting
          if (out_load) begin
            out_valid_q <= 1'b1;
            out_servo_q <= ch_q;
            out_pulse_q <= pulse_new;
            out_angle_q <= f_q;
            out_next_q  <= ch_q + sjf_pkg::CH_W'(1);
            state_q     <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_servo_q;
  assign m_axis_tdata  = {6'b0, out_next_q, out_angle_q, out_pulse_q};

endmodule

// File: rtl/sjf_mul_unit.sv
// Shared registered multiplier used for scaling and reciprocal division steps.
module sjf_mul_unit (
  input  logic                         clk_i,
  input  sjf_pkg::mul_req_t            req_i,
  output logic [sjf_pkg::MUL_P_W-1:0]  prod_o
);

  logic [sjf_pkg::MUL_P_W-1:0] prod_q;

  // Multiply and hold the product for the next sequencer step
  always_ff @(posedge clk_i) begin
    if (req_i.en) begin
      prod_q <= sjf_pkg::MUL_P_W'(req_i.a) * sjf_pkg::MUL_P_W'(req_i.b);
    end
  end

  assign prod_o = prod_q;

endmodule

// File: rtl/sjf_cfg_regs.sv
// Per-servo pulse range registers with write port and channel read-out.
module sjf_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           we_i,
  input  logic [sjf_pkg::CFG_IDX_W-1:0]  idx_i,
  input  logic [sjf_pkg::PULSE_W-1:0]    data_i,
  input  logic [sjf_pkg::CH_W-1:0]       ch_i,
  output sjf_pkg::servo_range_t          range_o
);

  logic [sjf_pkg::PULSE_W-1:0] lo_q [sjf_pkg::NUM_CH];
  logic [sjf_pkg::PULSE_W-1:0] hi_q [sjf_pkg::NUM_CH];

  // Write one register; drop writes beyond the register list
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < sjf_pkg::NUM_CH; i++) begin
        lo_q[i] <= sjf_pkg::LO_RESET;
        hi_q[i] <= sjf_pkg::HI_RESET;
      end
    end else if (we_i && (idx_i < sjf_pkg::CFG_IDX_W'(sjf_pkg::NUM_CFG))) begin
      if (idx_i[0]) begin
        hi_q[idx_i[sjf_pkg::CH_W:1]] <= data_i;
      end else begin
        lo_q[idx_i[sjf_pkg::CH_W:1]] <= data_i;
      end
    end
  end

  assign range_o.lo = lo_q[ch_i];
  assign range_o.hi = hi_q[ch_i];

endmodule

// File: dv/tb_servo_joystick_filter_map.sv
`timescale 1ns / 100ps
// Self-checking testbench for the four-channel joystick filter and servo pulse mapper.
module tb_servo_joystick_filter_map;
  import sjf_pkg::*;

  localparam int unsigned IDLE_PCT     = 24;
  localparam int unsigned STALL_LIMIT  = 1000;
  localparam int unsigned DRAIN_CYCLES = 12;
  localparam int unsigned PHASE_ITEMS  = 150;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERVO0_MIN = 4'd0,
    REG_SERVO0_MAX = 4'd1,
    REG_SERVO1_MIN = 4'd2,
    REG_SERVO1_MAX = 4'd3,
    REG_SERVO2_MIN = 4'd4,
    REG_SERVO2_MAX = 4'd5,
    REG_SERVO3_MIN = 4'd6,
    REG_SERVO3_MAX = 4'd7
  } range_reg_e;

  // Indexes from here up address no register
  localparam logic [CFG_IDX_W-1:0] FIRST_UNUSED_IDX = CFG_IDX_W'(NUM_CFG);

  typedef struct packed {
    logic [CH_W-1:0]    servo;
    logic [PULSE_W-1:0] pulse;
    logic [ANGLE_W-1:0] angle;
    logic [CH_W-1:0]    next_ch;
  } servo_update_t;

  // Tracks filter state and servo ranges, and holds the updates still due
  class servo_pulse_tracker;
    servo_range_t       ranges [NUM_CH];
    logic [ANGLE_W-1:0] angles [NUM_CH];
    servo_update_t      pending_updates [$];
    int unsigned        mismatches;

    function new();
      for (int i = 0; i < NUM_CH; i++) begin
        ranges[i].lo = LO_RESET;
        ranges[i].hi = HI_RESET;
        angles[i]    = '0;
      end
      mismatches = 0;
    endfunction

    function void set_range(logic [CFG_IDX_W-1:0] idx, logic [PULSE_W-1:0] val);
      if (idx >= FIRST_UNUSED_IDX) return;
      if (idx[0]) ranges[idx >> 1].hi = val;
      else ranges[idx >> 1].lo = val;
    endfunction

    // Joystick reading to degrees; channel 1 is inverted, channel 3 spans the full range
    function int unsigned sample_angle(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
      int unsigned level;
      level = (ch == INV_CH) ? 255 - smp : smp;
      if (ch == FULL_CH) return level * 180 / 255;
      if (level <= 127) return level * 180 / 127;
      return 180;
    endfunction

    function servo_update_t predict_update(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
      servo_update_t upd;
      int unsigned   smoothed;
      longint        lo;
      longint        hi;
      longint        span_sum;
      smoothed   = (sample_angle(ch, smp) * 10 + angles[ch] * 90) / 100;
      angles[ch] = smoothed[ANGLE_W-1:0];
      lo = ranges[ch].lo;
      hi = ranges[ch].hi;
      // signed span, division truncates toward zero, sum wraps to the pulse width
      span_sum = lo + (longint'(smoothed) * (hi - lo)) / 180;
      upd.servo   = ch;
      upd.pulse   = span_sum[PULSE_W-1:0];
      upd.angle   = smoothed[ANGLE_W-1:0];
      upd.next_ch = ch + 2'd1;
      return upd;
    endfunction

    function void note_sample(logic [CH_W-1:0] ch, logic [SAMPLE_W-1:0] smp);
      pending_updates.push_back(predict_update(ch, smp));
    endfunction

    function int unsigned outstanding();
      return pending_updates.size();
    endfunction

    task report_mismatch(string what);
      $display("[%0t] mismatch: %s", $realtime, what);
      mismatches++;
    endtask

    task check_update(servo_update_t got, logic [5:0] pad);
      servo_update_t want;
      if (pending_updates.size() == 0) begin
        report_mismatch($sformatf("unexpected update servo %0d pulse %0d angle %0d",
                                  got.servo, got.pulse, got.angle));
        return;
      end
      want = pending_updates.pop_front();
      if (got.servo != want.servo)
        report_mismatch($sformatf("servo %0d, want %0d", got.servo, want.servo));
      if (got.pulse != want.pulse)
        report_mismatch($sformatf("servo %0d pulse %0d, want %0d",
                                  want.servo, got.pulse, want.pulse));
      if (got.angle != want.angle)
        report_mismatch($sformatf("servo %0d filtered angle %0d, want %0d",
                                  want.servo, got.angle, want.angle));
      if (got.next_ch != want.next_ch)
        report_mismatch($sformatf("servo %0d next channel %0d, want %0d",
                                  want.servo, got.next_ch, want.next_ch));
      if (pad != '0)
        report_mismatch($sformatf("servo %0d padding bits 0x%0h", want.servo, pad));
    endtask
  endclass

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [7:0]           s_axis_tdata  = '0;  // [7:0] sample
  logic [1:0]           s_axis_tuser  = '0;  // [1:0] channel
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  // [15:0] pulse, [23:16] filtered_angle, [25:24] next_channel, rest zero
  logic [31:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;        // [1:0] servo
  logic                 cfg_we_i      = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_idx_i     = '0;
  logic [PULSE_W-1:0]   cfg_data_i    = '0;

  bit                   calm          = 1'b0;
  int unsigned          quiet_cycles  = 0;
  servo_pulse_tracker   tracker;

  servo_joystick_filter_map dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Stall the result side at random, except during the calm stretch
  always @(posedge clk_i) begin
    m_axis_tready <= calm || ($urandom_range(99) >= IDLE_PCT);
  end

  // Note accepted samples, check accepted updates, and watch for a hang
  always @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) tracker.note_sample(s_axis_tuser, s_axis_tdata);
    if (m_axis_tvalid && m_axis_tready)
      tracker.check_update({m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[23:16],
                            m_axis_tdata[25:24]}, m_axis_tdata[31:26]);
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
      $display("[%0t] no transaction for %0d cycles", $realtime, STALL_LIMIT);
      $display("FAIL servo_joystick_filter_map");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one sample, with random gaps ahead of it, and hold until it is taken
  task automatic send_sample(input logic [CH_W-1:0] ch, input logic [SAMPLE_W-1:0] smp);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= ch;
    s_axis_tdata  <= smp;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Drop valid and let the block drain before touching the range registers
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    while (tracker.outstanding() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_range(input logic [CFG_IDX_W-1:0] idx, input logic [PULSE_W-1:0] val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= val;
    tracker.set_range(idx, val);
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Load every range with a random bound, extremes often, plus one ignored write
  task automatic program_random_ranges();
    logic [PULSE_W-1:0] val;
    for (int i = 0; i < NUM_CFG; i++) begin
      case ($urandom_range(7))
        0:       val = '0;
        1:       val = '1;
        default: val = PULSE_W'($urandom_range(16'hFFFF));
      endcase
      write_range(CFG_IDX_W'(i), val);
    end
    write_range(FIRST_UNUSED_IDX + CFG_IDX_W'($urandom_range(7)),
                PULSE_W'($urandom_range(16'hFFFF)));
  endtask

  function automatic logic [SAMPLE_W-1:0] jitter(int target);
    int v;
    v = target + int'($urandom_range(16)) - 8;
    if (v < 0) v = 0;
    if (v > 255) v = 255;
    return SAMPLE_W'(v);
  endfunction

  // Random mix of steady stick positions so the filters settle, rotation scans and noise
  task automatic run_random(input int unsigned budget);
    int unsigned         sent;
    int unsigned         kind;
    int unsigned         len;
    int                  aims [NUM_CH];
    logic [CH_W-1:0]     ch;
    sent = 0;
    while (sent < budget) begin
      kind = $urandom_range(9);
      for (int c = 0; c < NUM_CH; c++) begin
        case ($urandom_range(3))
          0:       aims[c] = 0;
          1:       aims[c] = 255;
          default: aims[c] = $urandom_range(255);
        endcase
      end
      if (kind <= 3) begin
        // hold one stick steady
        ch  = CH_W'($urandom_range(NUM_CH - 1));
        len = $urandom_range(30, 5);
        for (int k = 0; k < len; k++) send_sample(ch, jitter(aims[ch]));
      end else if (kind <= 6) begin
        // scan the channels in converter order
        len = $urandom_range(40, 4);
        for (int k = 0; k < len; k++) send_sample(CH_W'(k), jitter(aims[k % NUM_CH]));
      end else begin
        len = $urandom_range(6, 1);
        for (int k = 0; k < len; k++)
          send_sample(CH_W'($urandom_range(NUM_CH - 1)), SAMPLE_W'($urandom_range(255)));
      end
      sent += len;
    end
  endtask

  initial begin
    logic [SAMPLE_W-1:0] corner_samples [4];
    corner_samples = '{8'd0, 8'd127, 8'd128, 8'd255};
    tracker = new();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset ranges: sample extremes and the fold at mid-scale on every channel
    for (int c = 0; c < NUM_CH; c++) begin
      foreach (corner_samples[j]) send_sample(CH_W'(c), corner_samples[j]);
    end
    send_sample(2'd0, 8'd1);
    send_sample(INV_CH, 8'd254);
    send_sample(FULL_CH, 8'd1);
    settle();

    // Widest, reversed and empty spans, and writes past the last register
    write_range(REG_SERVO0_MIN, 16'h0000);
    write_range(REG_SERVO0_MAX, 16'hFFFF);
    write_range(REG_SERVO1_MIN, 16'hFFFF);
    write_range(REG_SERVO1_MAX, 16'h0000);
    write_range(REG_SERVO2_MIN, 16'h0000);
    write_range(REG_SERVO2_MAX, 16'h0000);
    write_range(REG_SERVO3_MIN, 16'hFFFF);
    write_range(REG_SERVO3_MAX, 16'hFFFF);
    write_range(FIRST_UNUSED_IDX, 16'h1234);
    write_range('1, 16'hFFFF);
    run_random(PHASE_ITEMS);
    settle();

    program_random_ranges();
    run_random(PHASE_ITEMS);
    settle();

    // Narrow and reversed spans, with no idling on either side
    write_range(REG_SERVO0_MIN, 16'd500);
    write_range(REG_SERVO0_MAX, 16'd2500);
    write_range(REG_SERVO1_MIN, 16'd0);
    write_range(REG_SERVO1_MAX, 16'd180);
    write_range(REG_SERVO2_MIN, 16'd180);
    write_range(REG_SERVO2_MAX, 16'd0);
    write_range(REG_SERVO3_MIN, 16'd1234);
    write_range(REG_SERVO3_MAX, 16'd1000);
    calm = 1'b1;
    run_random(PHASE_ITEMS);
    calm = 1'b0;
    settle();

    program_random_ranges();
    run_random(PHASE_ITEMS);
    settle();

    program_random_ranges();
    run_random(PHASE_ITEMS);
    settle();

    if (tracker.mismatches == 0 && tracker.outstanding() == 0) begin
      $display("PASS servo_joystick_filter_map");
    end else begin
      $display("FAIL servo_joystick_filter_map");
    end
    $finish;
  end

endmodule
